// ----- rtl/bcd_clock_setting_menu_defines.svh -----
// Assertion macros for the BCD clock setting menu checker.
// Included by the checker file; needs nothing else.
`ifndef BCD_CLOCK_SETTING_MENU_DEFINES_SVH
`define BCD_CLOCK_SETTING_MENU_DEFINES_SVH

// same-cycle implication, off during reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcsm: same-cycle implication failed");

// next-cycle implication, off during reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcsm: next-cycle implication failed");

// next-cycle implication, always on
`define ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("bcsm: next-cycle implication failed");

`endif

// ----- rtl/bcsm_pkg.sv -----
// Package for the BCD clock setting menu: beat types, codes and constants.
// Used by every module of the block; depends on nothing.
`default_nettype none

package bcsm_pkg;

    localparam int QDEPTH_DEFAULT = 2;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_NEXT  = 2'd1,
        ACT_INC   = 2'd2,
        ACT_SAVE  = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        STEP_IDLE    = 4'd0,
        STEP_FORMAT  = 4'd1,
        STEP_HOUR    = 4'd2,
        STEP_AMPM    = 4'd3,
        STEP_MINUTE  = 4'd4,
        STEP_SECOND  = 4'd5,
        STEP_DATE    = 4'd6,
        STEP_MONTH   = 4'd7,
        STEP_YEAR    = 4'd8,
        STEP_WEEKDAY = 4'd9
    } step_t;

    typedef enum logic [2:0] {
        WP_HOUR    = 3'd0,
        WP_HOUR_PM = 3'd1,
        WP_MINUTE  = 3'd2,
        WP_SECOND  = 3'd3,
        WP_WEEKDAY = 3'd4,
        WP_DATE    = 3'd5,
        WP_MONTH   = 3'd6,
        WP_YEAR    = 3'd7
    } wr_pos_t;

    localparam logic [2:0] ADDR_SECOND  = 3'd0;
    localparam logic [2:0] ADDR_MINUTE  = 3'd1;
    localparam logic [2:0] ADDR_HOUR    = 3'd2;
    localparam logic [2:0] ADDR_WEEKDAY = 3'd3;
    localparam logic [2:0] ADDR_DATE    = 3'd4;
    localparam logic [2:0] ADDR_MONTH   = 3'd5;
    localparam logic [2:0] ADDR_YEAR    = 3'd6;

    localparam logic KIND_DISPLAY = 1'b0;
    localparam logic KIND_WRITE   = 1'b1;

    localparam logic [7:0] HOUR24_MAX = 8'h23;
    localparam logic [7:0] HOUR12_MAX = 8'h12;
    localparam logic [7:0] MINSEC_MAX = 8'h59;
    localparam logic [7:0] DATE_MAX   = 8'h31;
    localparam logic [7:0] MONTH_MAX  = 8'h12;
    localparam logic [7:0] YEAR_MAX   = 8'h99;
    localparam logic [7:0] MODE12_BIT = 8'h40;
    localparam logic [7:0] PM_BIT     = 8'h20;

    typedef struct packed {
        logic [1:0] action;
        logic [6:0] load_hour;
        logic [6:0] load_minute;
        logic [6:0] load_second;
        logic [2:0] load_weekday;
        logic [5:0] load_date;
        logic [4:0] load_month;
        logic [7:0] load_year;
        logic       load_twentyfour;
        logic       load_morning;
    } in_t;

    typedef struct packed {
        logic       kind;
        logic [3:0] menu_step;
        logic [7:0] shown_value;
        logic [2:0] write_address;
        logic [7:0] write_data;
        logic       last;
    } out_t;

    typedef struct packed {
        logic       is_save;
        logic [3:0] menu_step;
        logic [7:0] shown_value;
        logic [7:0] hour_byte;
        logic       pm_write;
        logic [6:0] minute;
        logic [6:0] second;
        logic [2:0] weekday;
        logic [5:0] date;
        logic [4:0] month;
        logic [7:0] year;
    } job_t;

endpackage

`default_nettype wire

// ----- rtl/bcsm_queue.sv -----
// Short job queue between the menu front end and the result sequencer.
// Depends on bcsm_pkg for the job type.
`default_nettype none

module bcsm_queue
    import bcsm_pkg::*;
#(
    parameter int DEPTH = QDEPTH_DEFAULT
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push_valid,
    output logic      push_ready,
    input  job_t      push_data,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output job_t      pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t            mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push, pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bcsm_front.sv -----
// Menu front end: takes button beats, updates the edited clock fields and
// issues one job per beat. Depends on bcsm_pkg.
`default_nettype none

module bcsm_front
    import bcsm_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  in_t       s_data,
    output logic      job_valid,
    input  wire logic job_ready,
    output job_t      job
);

    function automatic logic [8:0] bcd_inc(input logic [7:0] v, input logic [7:0] limit,
                                           input logic wrap);
        logic [8:0] s;
        s = {1'b0, v} + 9'd1;
        if (s > {1'b0, limit}) begin
            s = {8'd0, wrap};
        end
        if (s[3:0] > 4'd9) begin
            s = s + 9'd6;
        end
        return s;
    endfunction

    // 24-hour BCD above twelve to 12-hour BCD, kept to five bits
    function automatic logic [4:0] to_half(input logic [5:0] t);
        logic [5:0] tens;
        logic [5:0] bin;
        logic [5:0] rem;
        logic       odd;
        tens = {4'd0, t[5:4]};
        bin  = (tens << 3) + (tens << 1) + {2'd0, t[3:0]} - 6'd12;
        if (bin >= 6'd30) begin
            rem = bin - 6'd30;
            odd = 1'b1;
        end else if (bin >= 6'd20) begin
            rem = bin - 6'd20;
            odd = 1'b0;
        end else if (bin >= 6'd10) begin
            rem = bin - 6'd10;
            odd = 1'b1;
        end else begin
            rem = bin;
            odd = 1'b0;
        end
        return {odd, rem[3:0]};
    endfunction

    step_t      step_reg, step_next;
    logic [7:0] hour_full_reg, hour_full_next;
    logic [4:0] hour_half_reg, hour_half_next;
    logic       format_reg, format_next;
    logic       morning_reg, morning_next;
    logic [6:0] minute_reg, minute_next;
    logic [6:0] second_reg, second_next;
    logic [5:0] date_reg, date_next;
    logic [4:0] month_reg, month_next;
    logic [7:0] year_reg, year_next;
    logic [2:0] weekday_reg, weekday_next;

    logic       accept;
    logic       idle;
    logic       is_save;
    action_t    act;
    logic [8:0] inc_hour_full, inc_hour_half, inc_minute, inc_second;
    logic [8:0] inc_date, inc_month, inc_year;
    logic [3:0] wd_sum;
    logic [5:0] load_t;

    assign s_ready   = job_ready;
    assign job_valid = s_valid;
    assign accept    = s_valid && job_ready;
    assign act       = action_t'(s_data.action);
    assign idle      = !(step_reg inside {[STEP_FORMAT:STEP_WEEKDAY]});
    assign load_t    = s_data.load_hour[5:0];

    assign inc_hour_full = bcd_inc(hour_full_reg, HOUR24_MAX, 1'b0);
    assign inc_hour_half = bcd_inc({3'd0, hour_half_reg}, HOUR12_MAX, 1'b1);
    assign inc_minute    = bcd_inc({1'b0, minute_reg}, MINSEC_MAX, 1'b0);
    assign inc_second    = bcd_inc({1'b0, second_reg}, MINSEC_MAX, 1'b0);
    assign inc_date      = bcd_inc({2'd0, date_reg}, DATE_MAX, 1'b1);
    assign inc_month     = bcd_inc({3'd0, month_reg}, MONTH_MAX, 1'b1);
    assign inc_year      = bcd_inc(year_reg, YEAR_MAX, 1'b1);
    assign wd_sum        = {1'b0, weekday_reg} + 4'd1;

    always_comb begin
        step_next = step_reg;
        is_save   = 1'b0;
        case (act)
            ACT_START: step_next = STEP_FORMAT;
            ACT_NEXT: begin
                if (idle) begin
                    step_next = STEP_IDLE;
                end else if (step_reg == STEP_WEEKDAY) begin
                    step_next = STEP_IDLE;
                    is_save   = 1'b1;
                end else begin
                    step_next = step_t'(step_reg + 4'd1);
                end
            end
            ACT_INC: begin
                if (idle) begin
                    step_next = STEP_IDLE;
                end
            end
            ACT_SAVE: begin
                step_next = STEP_IDLE;
                is_save   = !idle;
            end
            default: step_next = step_reg;
        endcase
    end

    always_comb begin
        hour_full_next = hour_full_reg;
        hour_half_next = hour_half_reg;
        format_next    = format_reg;
        morning_next   = morning_reg;
        minute_next    = minute_reg;
        second_next    = second_reg;
        date_next      = date_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        weekday_next   = weekday_reg;
        if (act == ACT_START) begin
            hour_full_next = {1'b0, s_data.load_hour};
            minute_next    = s_data.load_minute;
            second_next    = s_data.load_second;
            weekday_next   = s_data.load_weekday;
            date_next      = s_data.load_date;
            month_next     = s_data.load_month;
            year_next      = s_data.load_year;
            format_next    = s_data.load_twentyfour;
            morning_next   = s_data.load_morning;
            if (({1'b0, s_data.load_hour} & MODE12_BIT) == 8'd0) begin
                if ({2'd0, load_t} > HOUR12_MAX) begin
                    morning_next   = 1'b0;
                    hour_half_next = to_half(load_t);
                end else if (load_t == 6'd0) begin
                    hour_half_next = HOUR12_MAX[4:0];
                end else begin
                    hour_half_next = load_t[4:0];
                end
            end else begin
                hour_half_next = s_data.load_hour[4:0];
            end
        end else if (act == ACT_INC && !idle) begin
            case (step_reg)
                STEP_FORMAT: format_next = !format_reg;
                STEP_HOUR: begin
                    if (format_reg) begin
                        hour_full_next = inc_hour_full[7:0];
                    end else begin
                        hour_half_next = inc_hour_half[4:0];
                    end
                end
                STEP_AMPM:    morning_next = !morning_reg;
                STEP_MINUTE:  minute_next  = inc_minute[6:0];
                STEP_SECOND:  second_next  = inc_second[6:0];
                STEP_DATE:    date_next    = inc_date[5:0];
                STEP_MONTH:   month_next   = inc_month[4:0];
                STEP_YEAR:    year_next    = inc_year[7:0];
                STEP_WEEKDAY: weekday_next = (wd_sum > 4'd7) ? 3'd1 : wd_sum[2:0];
                default:      weekday_next = weekday_reg;
            endcase
        end
    end

    always_comb begin
        job           = '0;
        job.is_save   = is_save;
        job.menu_step = step_next;
        case (step_next)
            STEP_FORMAT:  job.shown_value = {7'd0, format_next};
            STEP_HOUR:    job.shown_value = format_next ? hour_full_next
                                                        : {3'd0, hour_half_next};
            STEP_AMPM:    job.shown_value = {7'd0, morning_next};
            STEP_MINUTE:  job.shown_value = {1'b0, minute_next};
            STEP_SECOND:  job.shown_value = {1'b0, second_next};
            STEP_DATE:    job.shown_value = {2'd0, date_next};
            STEP_MONTH:   job.shown_value = {3'd0, month_next};
            STEP_YEAR:    job.shown_value = year_next;
            STEP_WEEKDAY: job.shown_value = {5'd0, weekday_next};
            default:      job.shown_value = 8'd0;
        endcase
        job.hour_byte = format_next ? hour_full_next : ({3'd0, hour_half_next} | MODE12_BIT);
        job.pm_write  = !format_next && !morning_next;
        job.minute    = minute_next;
        job.second    = second_next;
        job.weekday   = weekday_next;
        job.date      = date_next;
        job.month     = month_next;
        job.year      = year_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= STEP_IDLE;
            hour_full_reg <= '0;
            hour_half_reg <= '0;
            format_reg    <= 1'b0;
            morning_reg   <= 1'b0;
            minute_reg    <= '0;
            second_reg    <= '0;
            date_reg      <= '0;
            month_reg     <= '0;
            year_reg      <= '0;
            weekday_reg   <= '0;
        end else if (accept) begin
            step_reg      <= step_next;
            hour_full_reg <= hour_full_next;
            hour_half_reg <= hour_half_next;
            format_reg    <= format_next;
            morning_reg   <= morning_next;
            minute_reg    <= minute_next;
            second_reg    <= second_next;
            date_reg      <= date_next;
            month_reg     <= month_next;
            year_reg      <= year_next;
            weekday_reg   <= weekday_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bcsm_back.sv -----
// Result sequencer: turns each queued job into a display beat or the run of
// clock register writes, into an output register. Depends on bcsm_pkg.
`default_nettype none

module bcsm_back
    import bcsm_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic job_valid,
    output logic      job_ready,
    input  job_t      job,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    wr_pos_t pos_reg, pos_next;
    logic    m_valid_reg;
    out_t    m_data_reg;
    out_t    beat;
    logic    out_free;
    logic    emit;
    logic    last_beat;

    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = job_valid && out_free;
    assign last_beat = !job.is_save || (pos_reg == WP_YEAR);
    assign job_ready = emit && last_beat;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        pos_next = pos_reg;
        if (emit && job.is_save) begin
            case (pos_reg)
                WP_HOUR:    pos_next = job.pm_write ? WP_HOUR_PM : WP_MINUTE;
                WP_HOUR_PM: pos_next = WP_MINUTE;
                WP_MINUTE:  pos_next = WP_SECOND;
                WP_SECOND:  pos_next = WP_WEEKDAY;
                WP_WEEKDAY: pos_next = WP_DATE;
                WP_DATE:    pos_next = WP_MONTH;
                WP_MONTH:   pos_next = WP_YEAR;
                WP_YEAR:    pos_next = WP_HOUR;
                default:    pos_next = WP_HOUR;
            endcase
        end
    end

    always_comb begin
        beat = '0;
        if (!job.is_save) begin
            beat.kind        = KIND_DISPLAY;
            beat.menu_step   = job.menu_step;
            beat.shown_value = job.shown_value;
            beat.last        = 1'b1;
        end else begin
            beat.kind = KIND_WRITE;
            beat.last = (pos_reg == WP_YEAR);
            case (pos_reg)
                WP_HOUR: begin
                    beat.write_address = ADDR_HOUR;
                    beat.write_data    = job.hour_byte;
                end
                WP_HOUR_PM: begin
                    beat.write_address = ADDR_HOUR;
                    beat.write_data    = job.hour_byte | PM_BIT;
                end
                WP_MINUTE: begin
                    beat.write_address = ADDR_MINUTE;
                    beat.write_data    = {1'b0, job.minute};
                end
                WP_SECOND: begin
                    beat.write_address = ADDR_SECOND;
                    beat.write_data    = {1'b0, job.second};
                end
                WP_WEEKDAY: begin
                    beat.write_address = ADDR_WEEKDAY;
                    beat.write_data    = {5'd0, job.weekday};
                end
                WP_DATE: begin
                    beat.write_address = ADDR_DATE;
                    beat.write_data    = {2'd0, job.date};
                end
                WP_MONTH: begin
                    beat.write_address = ADDR_MONTH;
                    beat.write_data    = {3'd0, job.month};
                end
                WP_YEAR: begin
                    beat.write_address = ADDR_YEAR;
                    beat.write_data    = job.year;
                end
                default: begin
                    beat.write_address = ADDR_HOUR;
                    beat.write_data    = job.hour_byte;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= WP_HOUR;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            if (out_free) begin
                m_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= beat;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bcd_clock_setting_menu.sv -----
// Top level of the BCD clock setting menu: front end, job queue, sequencer.
// Depends on bcsm_pkg, bcsm_front, bcsm_queue and bcsm_back.
//
// Usage:
//   s_valid/s_ready/s_data carry button beats (start, next, increment, save)
//   with the clock values to load on start. m_valid/m_ready/m_data carry the
//   results: one display beat per button beat, or on save a run of clock
//   register writes (7 writes, 8 in 12-hour PM mode); last marks the final
//   result of each button beat.
//   The first result of a beat passes the job queue, then the output register.
//   Throughput: one display beat per cycle while m_ready is high; a save holds
//   the write sequencer for its writes, one write per cycle while m_ready is high.
//   The QUEUE_DEPTH-entry job queue lets new button beats in while a save drains.
//   Reset (aresetn low, synchronous): menu goes idle, all fields clear, the
//   queue empties and m_valid drops.
//   A stalled receiver holds the output register; once the queue fills,
//   s_ready drops until the sequencer moves on.
`default_nettype none

module bcd_clock_setting_menu
    import bcsm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QDEPTH_DEFAULT
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  in_t       s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    logic push_valid, push_ready;
    logic pop_valid, pop_ready;
    job_t push_job, pop_job;

    bcsm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job       (push_job)
    );

    bcsm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_job)
    );

    bcsm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// ----- rtl/bcsm_checker.sv -----
// Port-level checker for the BCD clock setting menu, bound to the top level.
// Depends on bcsm_pkg and bcd_clock_setting_menu_defines.svh.
`include "bcd_clock_setting_menu_defines.svh"
`default_nettype none

module bcsm_checker
    import bcsm_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input out_t      m_data
);

    logic is_display, is_write, write_more;
    logic display_clean, write_clean;

    assign is_display    = m_valid && (m_data.kind == KIND_DISPLAY);
    assign is_write      = m_valid && (m_data.kind == KIND_WRITE);
    assign write_more    = is_write && m_ready && !m_data.last;
    assign display_clean = m_data.last && (m_data.write_address == 3'd0)
                           && (m_data.write_data == 8'd0);
    assign write_clean   = (m_data.menu_step == STEP_IDLE) && (m_data.shown_value == 8'd0)
                           && (m_data.last == (m_data.write_address == ADDR_YEAR));

    `ASSERT_NXT_ALWAYS(a_reset_clears, aclk, !aresetn, !m_valid && s_ready)

    `ASSERT_IMP(a_display_form, aclk, aresetn, is_display, display_clean)

    `ASSERT_IMP(a_write_form, aclk, aresetn, is_write, write_clean)

    `ASSERT_NXT(a_write_run, aclk, aresetn, write_more, is_write)

    `ASSERT_NXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

endmodule

bind bcd_clock_setting_menu bcsm_checker u_bcsm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
